[hw/rtl/kpc_pkg.sv]
`timescale 1ns / 1ps

package kpc_pkg;

  // Default width of the press, release and lockout counters.
  localparam int unsigned COUNT_WIDTH_DEF = 8;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned LIMIT_W    = 8;

  // Register reset values.
  localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST   = 8'd3;
  localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST    = 8'd99;
  localparam logic [LIMIT_W-1:0] RELEASE_LIMIT_RST = 8'd3;
  localparam logic [LIMIT_W-1:0] LOCKOUT_LIMIT_RST = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_LIMIT   = 2'd0,
    REG_LONG_LIMIT    = 2'd1,
    REG_RELEASE_LIMIT = 2'd2,
    REG_LOCKOUT_LIMIT = 2'd3
  } kpc_reg_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] short_limit;
    logic [LIMIT_W-1:0] long_limit;
    logic [LIMIT_W-1:0] release_limit;
    logic [LIMIT_W-1:0] lockout_limit;
  } kpc_cfg_t;

  typedef struct packed {
    logic click;
    logic long_start;
    logic long_held;
    logic key_active;
    logic restart_step;
  } kpc_result_t;

endpackage

[hw/rtl/kpc_if.sv]
`timescale 1ns / 1ps

interface kpc_key_if;
  logic valid;
  logic ready;
  logic key_pin;

  modport source (output valid, output key_pin, input ready);
  modport sink   (input valid, input key_pin, output ready);
endinterface

interface kpc_result_if;
  logic valid;
  logic ready;
  logic click;
  logic long_start;
  logic long_held;
  logic key_active;
  logic restart_step;

  modport source (output valid, output click, output long_start, output long_held,
                  output key_active, output restart_step, input ready);
  modport sink   (input valid, input click, input long_start, input long_held,
                  input key_active, input restart_step, output ready);
endinterface

[hw/rtl/key_press_classifier_top.sv]
`timescale 1ns / 1ps

// Debounced short-click / long-press classifier for one active-low button.
// Input channel key_i carries one word per tick holding the raw pin sample
// (0 means pressed). Ticks alternate: one tick shifts the pin into a
// two-sample window, the next evaluates the window; the first tick after
// reset evaluates. Every accepted input word produces exactly one result
// word on result_o with the click, long_start, key_active and restart_step
// pulses and the long_held level.
// A word accepted at one clock edge is held in the input register; once the
// output register is free or being drained, the word is evaluated and loaded
// into the output register. While the receiver does not stall, a new word
// can be accepted in every cycle; the rate is one word per cycle, set by the
// single-pass evaluation between the input and output registers.
// If the receiver stalls, the result word is held and one more input word
// is taken into the input register; after that key_i.ready drops until the
// output register drains.
// The user must write the limit registers through cfg_we_i, cfg_idx_i and
// cfg_data_i only while the block is idle; the block does not enforce it.
// Reset (rst_ni low) restores the limit defaults, empties both registers
// and returns the sample window to released with all counters cleared.
module key_press_classifier_top #(
  parameter int unsigned COUNT_WIDTH = kpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  kpc_key_if.sink                          key_i,
  kpc_result_if.source                     result_o,
  input  logic                             cfg_we_i,
  input  logic [kpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kpc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  kpc_pkg::kpc_cfg_t    cfg_q, cfg_d;
  kpc_pkg::kpc_result_t core_res;
  kpc_pkg::kpc_result_t out_q;
  logic                 in_valid_q, in_valid_d;
  logic                 in_pin_q;
  logic                 out_valid_q, out_valid_d;
  logic                 advance;
  logic                 accept;

  // Configuration writes. Each index maps to one limit register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (kpc_pkg::kpc_reg_e'(cfg_idx_i))
        kpc_pkg::REG_SHORT_LIMIT:   cfg_d.short_limit   = cfg_data_i;
        kpc_pkg::REG_LONG_LIMIT:    cfg_d.long_limit    = cfg_data_i;
        kpc_pkg::REG_RELEASE_LIMIT: cfg_d.release_limit = cfg_data_i;
        kpc_pkg::REG_LOCKOUT_LIMIT: cfg_d.lockout_limit = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // The held input word moves on when the output register is free or is
  // being emptied in this cycle.
  assign advance     = in_valid_q && (!out_valid_q || result_o.ready);
  assign key_i.ready = !in_valid_q || advance;
  assign accept      = key_i.valid && key_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  kpc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .pin_i    (in_pin_q),
    .cfg_i    (cfg_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_limit   <= kpc_pkg::SHORT_LIMIT_RST;
      cfg_q.long_limit    <= kpc_pkg::LONG_LIMIT_RST;
      cfg_q.release_limit <= kpc_pkg::RELEASE_LIMIT_RST;
      cfg_q.lockout_limit <= kpc_pkg::LOCKOUT_LIMIT_RST;
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_pin_q <= key_i.key_pin;
    end
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.click        = out_q.click;
  assign result_o.long_start   = out_q.long_start;
  assign result_o.long_held    = out_q.long_held;
  assign result_o.key_active   = out_q.key_active;
  assign result_o.restart_step = out_q.restart_step;

  // A click comes from an accepted release, never with a long press start.
  a_click_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.click |->
      result_o.restart_step && !result_o.long_start && !result_o.key_active)
    else $error("click word with inconsistent companion flags");

  // A long press start raises the held level and restarts the step timer.
  a_long_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.long_start |->
      result_o.long_held && result_o.restart_step && result_o.key_active)
    else $error("long_start word without held level or restart");

  // While a stalled result waits, at most one more word is taken in.
  a_stall_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready && in_valid_q |-> !key_i.ready)
    else $error("input taken while both registers are full and stalled");

endmodule

[hw/rtl/kpc_core.sv]
`timescale 1ns / 1ps

module kpc_core #(
  parameter int unsigned COUNT_WIDTH = kpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                pin_i,
  input  kpc_pkg::kpc_cfg_t   cfg_i,
  output kpc_pkg::kpc_result_t result_o
);

  // Compares run at the wider of counter and limit width.
  localparam int unsigned CMP_W =
    (COUNT_WIDTH > kpc_pkg::LIMIT_W) ? COUNT_WIDTH : kpc_pkg::LIMIT_W;

  logic                   phase_q, phase_d;
  logic                   older_q, older_d;
  logic                   newer_q, newer_d;
  logic [COUNT_WIDTH-1:0] press_q, press_d;
  logic [COUNT_WIDTH-1:0] release_q, release_d;
  logic [COUNT_WIDTH-1:0] lockout_q, lockout_d;
  logic                   held_q, held_d;
  logic                   long_q, long_d;

  logic [COUNT_WIDTH-1:0] press_inc, release_inc;
  logic [CMP_W-1:0]       short_x, long_x, release_x, lockout_x;

  assign press_inc   = (press_q == '1) ? press_q : press_q + 1'b1;
  assign release_inc = (release_q == '1) ? release_q : release_q + 1'b1;
  assign short_x     = CMP_W'(cfg_i.short_limit);
  assign long_x      = CMP_W'(cfg_i.long_limit);
  assign release_x   = CMP_W'(cfg_i.release_limit);
  assign lockout_x   = CMP_W'(cfg_i.lockout_limit);

  always_comb begin
    phase_d   = phase_q;
    older_d   = older_q;
    newer_d   = newer_q;
    press_d   = press_q;
    release_d = release_q;
    lockout_d = lockout_q;
    held_d    = held_q;
    long_d    = long_q;
    result_o  = '0;
    if (step_i) begin
      if (phase_q) begin
        phase_d = 1'b0;
        older_d = newer_q;
        newer_d = pin_i;
      end else begin
        phase_d = 1'b1;
        if (!older_q && !newer_q) begin
          release_d           = '0;
          result_o.key_active = 1'b1;
          press_d             = press_inc;
          if (CMP_W'(press_inc) >= long_x) begin
            press_d = long_x[COUNT_WIDTH-1:0];
            if (!held_q) begin
              held_d                = 1'b1;
              long_d                = 1'b1;
              result_o.long_start   = 1'b1;
              result_o.restart_step = 1'b1;
            end
          end
        end else if (CMP_W'(release_inc) < release_x) begin
          release_d = release_inc;
        end else begin
          release_d = release_x[COUNT_WIDTH-1:0];
          if (lockout_q != '0) begin
            lockout_d = lockout_q - 1'b1;
            press_d   = '0;
          end else begin
            held_d = 1'b0;
            long_d = 1'b0;
            if (CMP_W'(press_q) >= short_x) begin
              press_d = '0;
              if (CMP_W'(press_q) != long_x) begin
                lockout_d             = lockout_x[COUNT_WIDTH-1:0];
                result_o.click        = 1'b1;
                result_o.restart_step = 1'b1;
              end
            end
          end
        end
      end
    end
    result_o.long_held = long_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= 1'b0;
      older_q   <= 1'b1;
      newer_q   <= 1'b1;
      press_q   <= '0;
      release_q <= '0;
      lockout_q <= '0;
      held_q    <= 1'b0;
      long_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      older_q   <= older_d;
      newer_q   <= newer_d;
      press_q   <= press_d;
      release_q <= release_d;
      lockout_q <= lockout_d;
      held_q    <= held_d;
      long_q    <= long_d;
    end
  end

endmodule

[dv/key_press_classifier_top_test.sv]
`timescale 1ns / 1ps

// Self-checking testbench for the key press classifier. A driver process feeds
// pin samples from a queue, a monitor process checks every result word against
// a cycle-free model of the classifier, and an initial block sequences the
// limit settings and fills the sample queue with press and release patterns.
module key_press_classifier_top_test;

  localparam int unsigned CNT_W = kpc_pkg::COUNT_WIDTH_DEF;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal pause is the forced receiver hold-off plus a long gap.
  localparam int IDLE_LIMIT = 2000;

  // The receiver blocks for a long stretch once this many results are checked.
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 120;

  // Number of limit settings after the reset defaults.
  localparam int NUM_SETTINGS = 8;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [kpc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  kpc_key_if    key_if ();
  kpc_result_if res_if ();

  key_press_classifier_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_i      (key_if),
    .result_o   (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Pin samples waiting to be offered, and result words predicted for
  // samples the block has already taken.
  bit                   pin_samples[$];
  kpc_pkg::kpc_result_t predicted_words[$];

  // Limits as the block currently holds them.
  logic [kpc_pkg::LIMIT_W-1:0] lim_short;
  logic [kpc_pkg::LIMIT_W-1:0] lim_long;
  logic [kpc_pkg::LIMIT_W-1:0] lim_release;
  logic [kpc_pkg::LIMIT_W-1:0] lim_lockout;

  // Classifier state. The held flag and the long level always move together,
  // so a single bit carries both.
  bit             eval_due;
  bit             win_old;
  bit             win_new;
  logic [CNT_W-1:0] press_cnt;
  logic [CNT_W-1:0] rel_cnt;
  logic [CNT_W-1:0] lock_cnt;
  bit             long_active;

  int mismatches = 0;
  int words_checked = 0;
  int clicks_seen = 0;
  int longs_seen = 0;
  int lockouts_seen;
  int samples_queued;

  // One tick of the classifier. Ticks alternate between shifting the pin into
  // the two-sample window and evaluating the window; the first tick after
  // reset evaluates.
  function automatic kpc_pkg::kpc_result_t classify_tick(bit pin);
    kpc_pkg::kpc_result_t res;
    res = '0;
    if (!eval_due) begin
      eval_due = 1'b1;
      win_old  = win_new;
      win_new  = pin;
    end else begin
      eval_due = 1'b0;
      if (!win_old && !win_new) begin
        // Both samples pressed: count press time, saturating at the long
        // limit, and announce the long press only once.
        rel_cnt = '0;
        res.key_active = 1'b1;
        if (press_cnt != CNT_MAX) press_cnt = press_cnt + 1'b1;
        if (press_cnt >= lim_long) begin
          press_cnt = lim_long;
          if (!long_active) begin
            long_active      = 1'b1;
            res.long_start   = 1'b1;
            res.restart_step = 1'b1;
          end
        end
      end else begin
        if (rel_cnt != CNT_MAX) rel_cnt = rel_cnt + 1'b1;
        if (rel_cnt >= lim_release) begin
          rel_cnt = lim_release;
          if (lock_cnt != '0) begin
            // Still locked out after a click: the press is thrown away.
            lock_cnt  = lock_cnt - 1'b1;
            press_cnt = '0;
          end else begin
            long_active = 1'b0;
            // A press below the short limit is dropped and keeps its count.
            if (press_cnt >= lim_short) begin
              if (press_cnt != lim_long) begin
                lock_cnt         = lim_lockout;
                res.click        = 1'b1;
                res.restart_step = 1'b1;
              end
              press_cnt = '0;
            end
          end
        end
      end
    end
    res.long_held = long_active;
    return res;
  endfunction

  function automatic int field_differs(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Most words follow without a gap or after a short one; a few gaps are long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Driver. At each rising edge it first books an accepted word into the
  // model, so the prediction is made in acceptance order, then decides what
  // to offer next. A word that follows directly keeps valid high with a single
  // assignment.
  // ---------------------------------------------------------------------------
  int  send_gap;
  int  send_steady;
  bit  send_taken;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_if.valid   <= 1'b0;
      key_if.key_pin <= 1'b1;
      send_gap       = 0;
      send_steady    = 0;
    end else begin
      send_taken = key_if.valid && key_if.ready;
      if (send_taken) begin
        predicted_words.push_back(classify_tick(key_if.key_pin));
        if (send_steady > 0) begin
          send_steady = send_steady - 1;
          send_gap    = 0;
        end else if ($urandom_range(0, 49) == 0) begin
          // Start a stretch of back-to-back words.
          send_steady = $urandom_range(40, 160);
          send_gap    = 0;
        end else begin
          send_gap = pick_gap();
        end
      end
      if (!key_if.valid || send_taken) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          key_if.valid <= 1'b0;
        end else if (pin_samples.size() != 0) begin
          key_if.valid   <= 1'b1;
          key_if.key_pin <= pin_samples.pop_front();
        end else begin
          key_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Checks each accepted result word against the oldest prediction
  // and throttles ready. Once, after HOLD_AFTER words, it blocks for a long
  // stretch while the driver keeps offering, so the block fills and has to
  // hold off its input.
  // ---------------------------------------------------------------------------
  int                   recv_stall;
  int                   recv_steady;
  bit                   hold_done;
  int                   roll_recv;
  kpc_pkg::kpc_result_t got_word;
  kpc_pkg::kpc_result_t want_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_stall   = 0;
      recv_steady  = 0;
      hold_done    = 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_word = {res_if.click, res_if.long_start, res_if.long_held,
                    res_if.key_active, res_if.restart_step};
        if (predicted_words.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          mismatches = mismatches + 1;
        end else begin
          want_word = predicted_words.pop_front();
          mismatches = mismatches
            + field_differs("click", want_word.click, got_word.click)
            + field_differs("long_start", want_word.long_start, got_word.long_start)
            + field_differs("long_held", want_word.long_held, got_word.long_held)
            + field_differs("key_active", want_word.key_active, got_word.key_active)
            + field_differs("restart_step", want_word.restart_step,
                            got_word.restart_step);
        end
        words_checked = words_checked + 1;
        if (got_word.click) clicks_seen = clicks_seen + 1;
        if (got_word.long_start) longs_seen = longs_seen + 1;
      end

      if (!hold_done && words_checked >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        recv_stall = HOLD_CYCLES;
      end else if (recv_stall == 0) begin
        if (recv_steady > 0) begin
          recv_steady = recv_steady - 1;
        end else begin
          roll_recv = $urandom_range(0, 99);
          if (roll_recv < 2) recv_steady = $urandom_range(40, 160);
          else if (roll_recv < 70) recv_stall = 0;
          else if (roll_recv < 94) recv_stall = $urandom_range(1, 3);
          else recv_stall = $urandom_range(8, 30);
        end
      end

      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog. Counts cycles in which work is outstanding but no word moves on
  // either channel.
  // ---------------------------------------------------------------------------
  int idle_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((key_if.valid && key_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (pin_samples.size() != 0 || predicted_words.size() != 0
                   || key_if.valid) begin
        if (idle_cycles + 1 >= IDLE_LIMIT) begin
          $error("no word moved for %0d cycles, %0d predicted words outstanding",
                 IDLE_LIMIT, predicted_words.size());
          $display("end of test: mismatches");
          $finish;
        end else begin
          idle_cycles <= idle_cycles + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_run(bit level, int ticks);
    repeat (ticks) begin
      pin_samples.push_back(level);
      samples_queued = samples_queued + 1;
    end
  endtask

  // Writes one limit register; the model follows at once since the block is
  // idle. Back-to-back writes keep the enable high across edges.
  task automatic write_limit(kpc_pkg::kpc_reg_e idx,
                             logic [kpc_pkg::LIMIT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      kpc_pkg::REG_SHORT_LIMIT:   lim_short   = value;
      kpc_pkg::REG_LONG_LIMIT:    lim_long    = value;
      kpc_pkg::REG_RELEASE_LIMIT: lim_release = value;
      kpc_pkg::REG_LOCKOUT_LIMIT: lim_lockout = value;
      default: ;
    endcase
  endtask

  task automatic apply_limits(kpc_pkg::kpc_cfg_t cfg);
    write_limit(kpc_pkg::REG_SHORT_LIMIT, cfg.short_limit);
    write_limit(kpc_pkg::REG_LONG_LIMIT, cfg.long_limit);
    write_limit(kpc_pkg::REG_RELEASE_LIMIT, cfg.release_limit);
    write_limit(kpc_pkg::REG_LOCKOUT_LIMIT, cfg.lockout_limit);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every queued sample has been taken and every predicted
  // word has come back, then lets the two-stage pipeline settle.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pin_samples.size() != 0 || predicted_words.size() != 0 || key_if.valid);
    repeat (4) @(posedge clk_i);
  endtask

  // One press and release episode. Press and release lengths are chosen in
  // evaluations relative to the current limits and turned into ticks, two per
  // evaluation plus a little jitter so the window phase varies.
  task automatic queue_episode();
    int kind;
    int evals;
    int second;
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      // Bouncing contact: random pin levels.
      repeat ($urandom_range(2, 14)) push_run(1'($urandom_range(0, 1)), 1);
      return;
    end
    if (kind <= 2) evals = (lim_short > 0) ? $urandom_range(0, lim_short - 1) : 0;
    else if (kind <= 6) evals = (lim_long > lim_short) ?
                                $urandom_range(lim_short, lim_long - 1) : lim_short;
    else if (kind <= 8) evals = lim_long + $urandom_range(0, 4);
    else evals = $urandom_range(0, lim_long + 2);
    push_run(1'b0, 2 * evals + $urandom_range(0, 2));
    if (kind == 11) begin
      // Release that is too short to be accepted, then the press goes on.
      second = (lim_release > 1) ? $urandom_range(0, lim_release - 2) : 0;
      push_run(1'b1, 2 * second + $urandom_range(0, 1));
      push_run(1'b0, 2 * $urandom_range(0, lim_long) + $urandom_range(0, 2));
    end
    if ($urandom_range(0, 4) == 0) begin
      // Early release: the next press may fall into the lockout window.
      second = $urandom_range(0, lim_release + lim_lockout);
    end else begin
      second = lim_release + lim_lockout + $urandom_range(0, 3);
      if (lim_lockout != 0) lockouts_seen = lockouts_seen + 1;
    end
    push_run(1'b1, 2 * second + $urandom_range(0, 2));
  endtask

  task automatic queue_episodes(int budget);
    int start;
    start = samples_queued;
    while (samples_queued - start < budget) queue_episode();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  kpc_pkg::kpc_cfg_t cfg;

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = kpc_pkg::REG_SHORT_LIMIT;
    cfg_data_i     = '0;
    lockouts_seen  = 0;
    samples_queued = 0;

    // Model state after reset: the window reads released, all counters clear
    // and the first tick evaluates.
    lim_short   = kpc_pkg::SHORT_LIMIT_RST;
    lim_long    = kpc_pkg::LONG_LIMIT_RST;
    lim_release = kpc_pkg::RELEASE_LIMIT_RST;
    lim_lockout = kpc_pkg::LOCKOUT_LIMIT_RST;
    eval_due    = 1'b1;
    win_old     = 1'b1;
    win_new     = 1'b1;
    press_cnt   = '0;
    rel_cnt     = '0;
    lock_cnt    = '0;
    long_active = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening with the reset limits: the released window on the
    // first evaluation, a press long enough to click, an accepted release
    // that arms the lockout, and a press swallowed while locked out.
    push_run(1'b1, 2);
    push_run(1'b0, 8);
    push_run(1'b1, 8);
    push_run(1'b0, 3);
    push_run(1'b1, 3);
    wait_drained();

    queue_episodes(100);
    wait_drained();

    for (int setting = 1; setting <= NUM_SETTINGS; setting++) begin
      case (setting)
        1: cfg = '{short_limit: 8'd1, long_limit: 8'd2, release_limit: 8'd1,
                   lockout_limit: 8'd0};
        2: cfg = '{short_limit: 8'd255, long_limit: 8'd255, release_limit: 8'd255,
                   lockout_limit: 8'd255};
        3: cfg = '{short_limit: 8'd2, long_limit: 8'd6, release_limit: 8'd2,
                   lockout_limit: 8'd1};
        // A short limit above the long limit can never give a click.
        4: cfg = '{short_limit: 8'd5, long_limit: 8'd3, release_limit: 8'd1,
                   lockout_limit: 8'd2};
        default: begin
          cfg.short_limit   = 8'($urandom_range(1, 8));
          cfg.long_limit    = 8'($urandom_range(2, 14));
          cfg.release_limit = 8'($urandom_range(1, 6));
          cfg.lockout_limit = 8'($urandom_range(0, 5));
        end
      endcase
      apply_limits(cfg);
      // The all-ones setting makes most episodes several hundred ticks long.
      queue_episodes((setting == 2) ? 400 : 60);
      wait_drained();
    end

    $display("Checked %0d result words over %0d limit settings after the defaults.",
             words_checked, NUM_SETTINGS);
    $display("Saw %0d clicks and %0d long presses; %0d releases ran into a lockout.",
             clicks_seen, longs_seen, lockouts_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
